### design/utf8ld_pkg.sv
// Package: shared types, byte-class constants and assembly functions for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8ld_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_BITS   = 8'h3F;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [BYTE_W-1:0] t_byte;

    // up to three code points produced by one input word
    typedef struct packed {
        logic [1:0]    cnt;
        logic          eot;
        t_cp [2:0]     cp;
    } t_bundle;

    function automatic logic [1:0] lead_need(input t_byte b);
        logic [1:0] need;
        if (b < ASCII_LIMIT) begin
            need = NEED_NONE;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            need = NEED_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            need = NEED_TWO;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            need = NEED_THREE;
        end else begin
            need = NEED_NONE;
        end
        return need;
    endfunction

    function automatic t_cp raw_cp(input t_byte b);
        return {{(CP_W-BYTE_W){1'b0}}, b};
    endfunction

    function automatic t_cp asm2(input t_byte a, input t_byte b);
        t_byte ma;
        t_byte mb;
        ma = a & LEAD2_BITS;
        mb = b & CONT_BITS;
        return {10'b0, ma[4:0], mb[5:0]};
    endfunction

    function automatic t_cp asm3(input t_byte a, input t_byte b, input t_byte c);
        t_byte ma;
        t_byte mb;
        t_byte mc;
        ma = a & LEAD3_BITS;
        mb = b & CONT_BITS;
        mc = c & CONT_BITS;
        return {5'b0, ma[3:0], mb[5:0], mc[5:0]};
    endfunction

    function automatic t_cp asm4(input t_byte a, input t_byte b, input t_byte c,
                                 input t_byte d);
        t_byte ma;
        t_byte mb;
        t_byte mc;
        t_byte md;
        ma = a & LEAD4_BITS;
        mb = b & CONT_BITS;
        mc = c & CONT_BITS;
        md = d & CONT_BITS;
        return {ma[2:0], mb[5:0], mc[5:0], md[5:0]};
    endfunction

endpackage

### design/utf8ld_core.sv
// Input register, held-sequence state and single-pass decode into a result bundle.
`timescale 1ns / 1ps

module utf8ld_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  utf8ld_pkg::t_byte  i_byte_in,
    input  logic               i_end_of_text,
    input  logic               i_take_ok,
    output logic               o_load,
    output utf8ld_pkg::t_bundle o_bundle
);
    import utf8ld_pkg::*;

    logic        r_in_valid;
    t_byte       r_byte;
    logic        r_eot;
    t_byte       r_held [3];
    logic [1:0]  r_count;
    logic [1:0]  r_need;

    t_byte       n_held [3];
    logic [1:0]  n_count;
    logic [1:0]  n_need;

    logic [1:0]  pre_count;
    logic [1:0]  need_b;
    logic        main_valid;
    t_cp         main_cp;
    logic        flush;
    logic        advance;
    t_bundle     bundle;

    always_comb begin
        n_held     = r_held;
        pre_count  = r_count;
        n_need     = r_need;
        main_valid = 1'b0;
        main_cp    = '0;
        need_b     = lead_need(r_byte);

        if (r_count == 2'd0) begin
            if (need_b == NEED_NONE) begin
                main_valid = 1'b1;
                main_cp    = raw_cp(r_byte);
            end else begin
                n_held[0] = r_byte;
                pre_count = 2'd1;
                n_need    = need_b;
            end
        end else if (r_count == r_need) begin
            main_valid = 1'b1;
            case (r_need)
                NEED_ONE: main_cp = asm2(r_held[0], r_byte);
                NEED_TWO: main_cp = asm3(r_held[0], r_held[1], r_byte);
                default:  main_cp = asm4(r_held[0], r_held[1], r_held[2], r_byte);
            endcase
            pre_count = 2'd0;
            n_need    = NEED_NONE;
        end else begin
            n_held[r_count] = r_byte;
            pre_count       = r_count + 2'd1;
        end

        // end of text inside a sequence: lead goes out raw, rest re-decoded
        flush        = r_eot && (pre_count != 2'd0);
        bundle.eot   = r_eot;
        bundle.cp[0] = main_cp;
        bundle.cp[1] = raw_cp(n_held[1]);
        bundle.cp[2] = raw_cp(n_held[2]);
        bundle.cnt   = main_valid ? 2'd1 : 2'd0;
        n_count      = pre_count;

        if (flush) begin
            bundle.cp[0] = raw_cp(n_held[0]);
            n_count      = 2'd0;
            n_need       = NEED_NONE;
            case (pre_count)
                2'd1: bundle.cnt = 2'd1;
                2'd2: bundle.cnt = 2'd2;
                default: begin
                    if (lead_need(n_held[1]) == NEED_ONE) begin
                        bundle.cnt   = 2'd2;
                        bundle.cp[1] = asm2(n_held[1], n_held[2]);
                    end else begin
                        bundle.cnt = 2'd3;
                    end
                end
            endcase
        end
    end

    assign advance  = r_in_valid && ((bundle.cnt == 2'd0) || i_take_ok);
    assign o_load   = r_in_valid && (bundle.cnt != 2'd0) && i_take_ok;
    assign o_bundle = bundle;
    assign o_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= 2'd0;
            r_need     <= NEED_NONE;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_count <= n_count;
                r_need  <= n_need;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte_in;
            r_eot  <= i_end_of_text;
        end
        if (advance) begin
            r_held <= n_held;
        end
    end

endmodule

### design/utf8ld_emit.sv
// Result register: holds one bundle and sends its code points one word per cycle while the receiver is ready.
`timescale 1ns / 1ps

module utf8ld_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  utf8ld_pkg::t_bundle i_bundle,
    output logic                o_take_ok,
    output logic                o_valid,
    input  logic                i_ready,
    output utf8ld_pkg::t_cp     o_code_point,
    output logic                o_last_of_run,
    output logic                o_text_done
);
    import utf8ld_pkg::*;

    t_cp [2:0]  r_cp;
    logic [1:0] r_rem;
    logic       r_eot;
    logic       shift;

    assign o_valid       = (r_rem != 2'd0);
    assign shift         = o_valid && i_ready;
    assign o_take_ok     = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_ready);
    assign o_code_point  = r_cp[0];
    assign o_last_of_run = (r_rem == 2'd1);
    assign o_text_done   = (r_rem == 2'd1) && r_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
        end else if (i_load) begin
            r_rem <= i_bundle.cnt;
        end else if (shift) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp  <= i_bundle.cp;
            r_eot <= i_bundle.eot;
        end else if (shift) begin
            r_cp[0] <= r_cp[1];
            r_cp[1] <= r_cp[2];
        end
    end

endmodule

### design/utf8_lenient_decoder_unit.sv
// Top level of the lenient UTF-8 decoder: input stage plus result serializer.
// Path: the accepted input word is registered in the core, decoded, then registered in the result serializer.
// Throughput: one byte per cycle while the receiver is ready; a byte that ends the text inside a
// sequence yields up to 3 results, one per cycle while the receiver is ready, and input stalls while they drain.
// Reset: synchronous active-low; clears held count, pending input and results.
`timescale 1ns / 1ps

module utf8_lenient_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  utf8ld_pkg::t_byte   i_byte_in,
    input  logic                i_end_of_text,
    output logic                o_valid,
    input  logic                i_ready,
    output utf8ld_pkg::t_cp     o_code_point,
    output logic                o_last_of_run,
    output logic                o_text_done
);
    import utf8ld_pkg::*;

    logic    load;
    logic    take_ok;
    t_bundle bundle;

    utf8ld_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_in     (i_byte_in),
        .i_end_of_text (i_end_of_text),
        .i_take_ok     (take_ok),
        .o_load        (load),
        .o_bundle      (bundle)
    );

    utf8ld_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_bundle      (bundle),
        .o_take_ok     (take_ok),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

endmodule

### design/utf8ld_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8ld_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input utf8ld_pkg::t_byte i_byte_in,
    input logic              i_end_of_text,
    input logic              o_valid,
    input logic              i_ready,
    input utf8ld_pkg::t_cp   o_code_point,
    input logic              o_last_of_run,
    input logic              o_text_done
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point)
            && $stable(o_last_of_run) && $stable(o_text_done))
        else $error("result word changed while stalled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_done |-> o_last_of_run)
        else $error("text_done without last_of_run");

    // remaining results of one byte follow without a gap
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid)
        else $error("run of results broken");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind utf8_lenient_decoder_unit utf8ld_checker u_checker (.*);

### test/tb_top.sv
// Self-checking testbench for the lenient UTF-8 decoder: directed and random byte strings.
`timescale 1ns / 1ps

module tb_top;
    import utf8ld_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIRECTED_N  = 25;

    typedef struct packed {
        t_byte b;
        logic  eot;
    } t_in_word;

    typedef struct packed {
        t_cp  cp;
        logic last;
        logic done;
    } t_cp_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_byte i_byte_in = '0;
    logic i_end_of_text = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_cp o_code_point;
    logic o_last_of_run;
    logic o_text_done;

    t_in_word pending_bytes[$];
    t_cp_word expected_cps[$];

    // decoder shadow state
    t_byte dec_held [3];
    int dec_count = 0;
    logic [1:0] dec_need = NEED_NONE;

    logic [8:0] directed_bytes [DIRECTED_N];
    logic in_fire = 1'b0;
    logic hold_rx = 1'b0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int cycles = 0;
    t_in_word next_word;
    t_cp_word want_word;

    utf8_lenient_decoder_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_byte_in    (i_byte_in),
        .i_end_of_text(i_end_of_text),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_last_of_run(o_last_of_run),
        .o_text_done  (o_text_done)
    );

    function automatic logic [1:0] seq_need(input t_byte b);
        casez (b)
            8'b110?????: return NEED_ONE;
            8'b1110????: return NEED_TWO;
            8'b11110???: return NEED_THREE;
            default:     return NEED_NONE;
        endcase
    endfunction

    function automatic t_cp pack_cp(input t_byte a, input t_byte b, input t_byte c,
                                    input t_byte d, input logic [1:0] need);
        t_cp v;
        v = '0;
        case (need)
            NEED_ONE:   v = t_cp'({a[4:0], b[5:0]});
            NEED_TWO:   v = t_cp'({a[3:0], b[5:0], c[5:0]});
            NEED_THREE: v = t_cp'({a[2:0], b[5:0], c[5:0], d[5:0]});
            default:    v = t_cp'(a);
        endcase
        return v;
    endfunction

    task automatic decode_byte(input t_byte b, input logic eot);
        t_cp outs [3];
        t_byte seq [6];
        int n;
        int i;
        logic [1:0] nd;
        t_cp_word w;
        n = 0;
        for (i = 0; i < 6; i++) seq[i] = '0;
        if (dec_count == 0) begin
            nd = seq_need(b);
            if (nd == NEED_NONE) begin
                outs[n] = t_cp'(b);
                n++;
            end else begin
                dec_held[0] = b;
                dec_count = 1;
                dec_need = nd;
            end
        end else if (dec_count == int'(dec_need)) begin
            for (i = 0; i < dec_count; i++) seq[i] = dec_held[i];
            seq[dec_count] = b;
            outs[n] = pack_cp(seq[0], seq[1], seq[2], seq[3], dec_need);
            n++;
            dec_count = 0;
            dec_need = NEED_NONE;
        end else begin
            dec_held[dec_count] = b;
            dec_count++;
        end
        // text ends inside a sequence: re-decode what is held
        if (eot && dec_count != 0) begin
            for (i = 0; i < dec_count; i++) seq[i] = dec_held[i];
            i = 0;
            while (i < dec_count) begin
                nd = seq_need(seq[i]);
                if (nd != NEED_NONE && i + int'(nd) < dec_count) begin
                    outs[n] = pack_cp(seq[i], seq[i+1], seq[i+2], seq[i+3], nd);
                    i += int'(nd) + 1;
                end else begin
                    outs[n] = t_cp'(seq[i]);
                    i++;
                end
                n++;
            end
            dec_count = 0;
            dec_need = NEED_NONE;
        end
        for (i = 0; i < n; i++) begin
            w.cp = outs[i];
            w.last = (i == n - 1);
            w.done = (i == n - 1) && eot;
            expected_cps.push_back(w);
        end
    endtask

    task automatic push_word(input t_byte b, input logic eot);
        t_in_word w;
        w.b = b;
        w.eot = eot;
        pending_bytes.push_back(w);
    endtask

    task automatic add_text();
        t_byte seq [4];
        int nchars;
        int k;
        int j;
        int kind;
        int nb;
        nchars = $urandom_range(1, 6);
        for (k = 0; k < nchars; k++) begin
            kind = $urandom_range(0, 99);
            nb = 1;
            for (j = 0; j < 4; j++) seq[j] = t_byte'(8'h80 | $urandom_range(0, 63));
            if (kind < 30) begin
                seq[0] = t_byte'($urandom_range(1, 127));
            end else if (kind < 50) begin
                seq[0] = t_byte'(8'hC0 | $urandom_range(0, 31));
                nb = 2;
            end else if (kind < 65) begin
                seq[0] = t_byte'(8'hE0 | $urandom_range(0, 15));
                nb = 3;
            end else if (kind < 78) begin
                seq[0] = t_byte'(8'hF0 | $urandom_range(0, 7));
                nb = 4;
            end else if (kind < 88) begin
                seq[0] = t_byte'($urandom_range(1, 255));
            end else begin
                // lead byte followed by arbitrary bytes
                nb = $urandom_range(2, 4);
                case (nb)
                    2: seq[0] = t_byte'(8'hC0 | $urandom_range(0, 31));
                    3: seq[0] = t_byte'(8'hE0 | $urandom_range(0, 15));
                    default: seq[0] = t_byte'(8'hF0 | $urandom_range(0, 7));
                endcase
                for (j = 1; j < nb; j++) seq[j] = t_byte'($urandom_range(1, 255));
            end
            if (k == nchars - 1 && nb > 1 && $urandom_range(0, 3) == 0) begin
                nb = $urandom_range(1, nb - 1);
            end
            for (j = 0; j < nb; j++) begin
                push_word(seq[j], (k == nchars - 1) && (j == nb - 1));
            end
        end
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < 40) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_byte_in <= '0;
            i_end_of_text <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                next_word = pending_bytes.pop_front();
                i_byte_in <= next_word.b;
                i_end_of_text <= next_word.eot;
                i_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
                tx_gap = pick_gap(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            rx_gap = pick_gap(rx_calm);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                decode_byte(i_byte_in, i_end_of_text);
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_cps.size() == 0) begin
                    report_mismatch($sformatf("unexpected word cp=%h", o_code_point));
                end else begin
                    want_word = expected_cps.pop_front();
                    if (o_code_point !== want_word.cp)
                        report_mismatch($sformatf("code_point %h, want %h",
                                                  o_code_point, want_word.cp));
                    if (o_last_of_run !== want_word.last)
                        report_mismatch($sformatf("last_of_run %b, want %b (cp %h)",
                                                  o_last_of_run, want_word.last, want_word.cp));
                    if (o_text_done !== want_word.done)
                        report_mismatch($sformatf("text_done %b, want %b (cp %h)",
                                                  o_text_done, want_word.done, want_word.cp));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver stall so the decoder backs up into its input
    initial begin
        while (n_accepted < 100) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        // bit 8 marks end of text
        directed_bytes = '{
            9'h001, 9'h07F, 9'h080, 9'h0FF, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
            9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
            9'h0F0, 9'h0C3, 9'h1A9,
            9'h0F4, 9'h0E1, 9'h141,
            9'h1C5,
            9'h0E0, 9'h000, 9'h080, 9'h000, 9'h141
        };
        for (int i = 0; i < DIRECTED_N; i++) begin
            push_word(directed_bytes[i][7:0], directed_bytes[i][8]);
        end
        while (pending_bytes.size() < 200) add_text();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_cps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
